// ----- rtl/lcd_three_wire_frame_serializer_assert.svh -----
// ---------------------------------------------------------------------------
// lcd three-wire frame serializer assertion macros
// shared concurrent assertion forms, reset disables checking
// ---------------------------------------------------------------------------
`ifndef LCD_THREE_WIRE_FRAME_SERIALIZER_ASSERT_SVH
`define LCD_THREE_WIRE_FRAME_SERIALIZER_ASSERT_SVH

// same-cycle implication
`define LTW_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error("serializer same-cycle check failed");

// next-cycle implication
`define LTW_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error("serializer next-cycle check failed");

`endif

// ----- rtl/lcdtw_pkg.sv -----
// ---------------------------------------------------------------------------
// lcdtw_pkg
// constants and codes for the three-wire lcd frame serializer
// ---------------------------------------------------------------------------
package lcdtw_pkg;

  localparam int ADDRESS_BITS = 6;
  localparam int DATA_BITS    = 8;
  localparam int CMD_BITS     = 8;
  localparam int MODE_BITS    = 3;

  localparam int BODY_W_WRITE = ADDRESS_BITS + DATA_BITS;
  localparam int BODY_W_CMD   = CMD_BITS + 1;
  localparam int BODY_W_MAX   = (BODY_W_WRITE > BODY_W_CMD) ? BODY_W_WRITE : BODY_W_CMD;
  localparam int SEQ_W        = MODE_BITS + BODY_W_MAX;
  localparam int CNT_W        = $clog2(SEQ_W + 1);

  localparam int LEN_CMD_OPEN   = MODE_BITS + BODY_W_CMD;
  localparam int LEN_CMD_CONT   = BODY_W_CMD;
  localparam int LEN_WRITE_OPEN = MODE_BITS + BODY_W_WRITE;
  localparam int LEN_WRITE_CONT = DATA_BITS;

  localparam logic       OP_CMD   = 1'b0;
  localparam logic       OP_WRITE = 1'b1;

  localparam logic [MODE_BITS-1:0] MODE_CMD   = 3'b100;
  localparam logic [MODE_BITS-1:0] MODE_WRITE = 3'b101;

  localparam logic CMD_TRAIL_BIT = 1'b0;

  typedef logic [SEQ_W-1:0] seq_word_t;
  typedef logic [CNT_W-1:0] bit_cnt_t;

endpackage

// ----- rtl/lcd_three_wire_frame_serializer.sv -----
// ---------------------------------------------------------------------------
// lcd_three_wire_frame_serializer
// turns command and display write items into mode, address and data bits
// ---------------------------------------------------------------------------
// first bit: a taken item is loaded into the shift register and bit counter,
//   and its first bit then moves into the output register
// throughput: one bit per cycle through the shared shift register when the
//   output is not stalled; an item of n bits (8 to 17) holds the input until its last bit is sent
// reset: rst_n synchronous, clears the bit counter, output valid and frame state
module lcd_three_wire_frame_serializer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_operation,
  input  logic [7:0] in_payload,
  input  logic [5:0] in_address,
  input  logic       in_close_frame,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_data_bit,
  output logic       out_frame_start,
  output logic       out_frame_end,
  output logic       out_last
);

  `include "lcd_three_wire_frame_serializer_assert.svh"

  localparam int SEQ_W = lcdtw_pkg::SEQ_W;
  localparam int CNT_W = lcdtw_pkg::CNT_W;

  lcdtw_pkg::seq_word_t shift_r, shift_nxt, load_word;
  lcdtw_pkg::bit_cnt_t  cnt_r, cnt_nxt, load_cnt;
  logic frame_open_r, frame_open_nxt;
  logic frame_kind_r, frame_kind_nxt;
  logic start_pend_r, start_pend_nxt;
  logic close_r, close_nxt;
  logic out_valid_r, out_valid_nxt;
  logic data_bit_r, data_bit_nxt;
  logic frame_start_r, frame_start_nxt;
  logic frame_end_r, frame_end_nxt;
  logic last_r, last_nxt;

  logic accept, emit, opening, last_bit;
  logic [lcdtw_pkg::ADDRESS_BITS-1:0] addr_sel;
  logic [lcdtw_pkg::DATA_BITS-1:0]    data_sel;

  assign in_stall = (cnt_r != '0);
  assign accept   = in_valid && !in_stall;
  assign emit     = (cnt_r != '0) && (!out_valid_r || !out_stall);
  assign last_bit = (cnt_r == CNT_W'(1));
  assign opening  = !frame_open_r || (frame_kind_r != in_operation);
  assign addr_sel = lcdtw_pkg::ADDRESS_BITS'(in_address);
  assign data_sel = lcdtw_pkg::DATA_BITS'(in_payload);

  // left-aligned bit sequence for the incoming item
  always_comb begin
    load_word = '0;
    load_cnt  = '0;
    case ({in_operation, opening})
      {lcdtw_pkg::OP_CMD, 1'b1}: begin
        load_word = SEQ_W'({lcdtw_pkg::MODE_CMD, in_payload, lcdtw_pkg::CMD_TRAIL_BIT})
                    << (SEQ_W - lcdtw_pkg::LEN_CMD_OPEN);
        load_cnt  = CNT_W'(lcdtw_pkg::LEN_CMD_OPEN);
      end
      {lcdtw_pkg::OP_CMD, 1'b0}: begin
        load_word = SEQ_W'({in_payload, lcdtw_pkg::CMD_TRAIL_BIT})
                    << (SEQ_W - lcdtw_pkg::LEN_CMD_CONT);
        load_cnt  = CNT_W'(lcdtw_pkg::LEN_CMD_CONT);
      end
      {lcdtw_pkg::OP_WRITE, 1'b1}: begin
        load_word = SEQ_W'({lcdtw_pkg::MODE_WRITE, addr_sel, data_sel})
                    << (SEQ_W - lcdtw_pkg::LEN_WRITE_OPEN);
        load_cnt  = CNT_W'(lcdtw_pkg::LEN_WRITE_OPEN);
      end
      default: begin
        load_word = SEQ_W'(data_sel) << (SEQ_W - lcdtw_pkg::LEN_WRITE_CONT);
        load_cnt  = CNT_W'(lcdtw_pkg::LEN_WRITE_CONT);
      end
    endcase
  end

  always_comb begin
    shift_nxt       = shift_r;
    cnt_nxt         = cnt_r;
    frame_open_nxt  = frame_open_r;
    frame_kind_nxt  = frame_kind_r;
    start_pend_nxt  = start_pend_r;
    close_nxt       = close_r;
    out_valid_nxt   = out_valid_r;
    data_bit_nxt    = data_bit_r;
    frame_start_nxt = frame_start_r;
    frame_end_nxt   = frame_end_r;
    last_nxt        = last_r;
    if (accept) begin
      shift_nxt      = load_word;
      cnt_nxt        = load_cnt;
      start_pend_nxt = opening;
      close_nxt      = in_close_frame;
      frame_open_nxt = !in_close_frame;
      frame_kind_nxt = in_operation;
    end
    if (emit) begin
      shift_nxt       = shift_r << 1;
      cnt_nxt         = cnt_r - CNT_W'(1);
      start_pend_nxt  = 1'b0;
      out_valid_nxt   = 1'b1;
      data_bit_nxt    = shift_r[SEQ_W-1];
      frame_start_nxt = start_pend_r;
      frame_end_nxt   = last_bit && close_r;
      last_nxt        = last_bit;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      frame_open_r <= 1'b0;
      frame_kind_r <= lcdtw_pkg::OP_CMD;
      start_pend_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      frame_open_r <= frame_open_nxt;
      frame_kind_r <= frame_kind_nxt;
      start_pend_r <= start_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r       <= shift_nxt;
    close_r       <= close_nxt;
    data_bit_r    <= data_bit_nxt;
    frame_start_r <= frame_start_nxt;
    frame_end_r   <= frame_end_nxt;
    last_r        <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_data_bit    = data_bit_r;
  assign out_frame_start = frame_start_r;
  assign out_frame_end   = frame_end_r;
  assign out_last        = last_r;

  `LTW_ASSERT_NEXT(a_accept_loads_bits, clk, rst_n, accept, cnt_r != '0)
  `LTW_ASSERT_SAME(a_end_on_last, clk, rst_n, out_valid && out_frame_end, out_last)
  `LTW_ASSERT_NEXT(a_final_bit_marked, clk, rst_n, emit && last_bit,
                   out_valid && out_last && !in_stall)
  `LTW_ASSERT_NEXT(a_start_only_first, clk, rst_n, emit && !accept, !start_pend_r)

endmodule

// ----- bench/lcd_three_wire_frame_serializer_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcd_three_wire_frame_serializer_test
// bit-level check of every serial transaction against a frame model
// directed frames first, then random bursts, output stalls, hold-off and drain
// ---------------------------------------------------------------------------
module lcd_three_wire_frame_serializer_test;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 350;
  localparam int DRAIN_INDEX  = 200;

  localparam int STALL_NONE    = 0;
  localparam int STALL_LIGHT   = 1;
  localparam int STALL_HEAVY   = 2;
  localparam int STALL_PATTERN = 3;

  typedef struct packed {
    logic       op;
    logic [7:0] payload;
    logic [5:0] address;
    logic       close;
    logic       drain;
  } lcd_item_t;

  typedef struct packed {
    logic data_bit;
    logic frame_start;
    logic frame_end;
    logic last;
  } lcd_bit_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_operation = lcdtw_pkg::OP_CMD;
  logic [7:0] in_payload = 8'h00;
  logic [5:0] in_address = 6'h00;
  logic       in_close_frame = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_data_bit;
  logic       out_frame_start;
  logic       out_frame_end;
  logic       out_last;

  lcd_item_t pending_items[$];
  lcd_bit_t  expected_bits[$];

  logic link_open = 1'b0;
  logic link_kind = lcdtw_pkg::OP_CMD;
  int   items_taken = 0;
  int   mismatches = 0;
  int   cycles = 0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   holdoff_left = 0;
  bit   holdoff_done = 1'b0;
  int   stall_mode = STALL_NONE;
  int   phase_left = 0;
  int   pattern_cnt = 0;

  lcd_three_wire_frame_serializer u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_payload      (in_payload),
    .in_address      (in_address),
    .in_close_frame  (in_close_frame),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data_bit    (out_data_bit),
    .out_frame_start (out_frame_start),
    .out_frame_end   (out_frame_end),
    .out_last        (out_last)
  );

  always #6 clk = ~clk;

  // bit sequence of one item on the serial link
  task automatic serialize_item(input logic op, input logic [7:0] payload,
                                input logic [5:0] address, input logic close);
    lcd_bit_t                        seq [0:31];
    int                              n;
    int                              i;
    logic                            opening;
    logic [lcdtw_pkg::MODE_BITS-1:0] mode;
    n = 0;
    opening = !link_open || (link_kind != op);
    if (opening) begin
      mode = (op == lcdtw_pkg::OP_WRITE) ? lcdtw_pkg::MODE_WRITE : lcdtw_pkg::MODE_CMD;
      for (i = lcdtw_pkg::MODE_BITS - 1; i >= 0; i--) begin
        seq[n] = '{mode[i], (i == lcdtw_pkg::MODE_BITS - 1), 1'b0, 1'b0};
        n++;
      end
      link_open = 1'b1;
      link_kind = op;
    end
    if (op == lcdtw_pkg::OP_CMD) begin
      for (i = lcdtw_pkg::CMD_BITS - 1; i >= 0; i--) begin
        seq[n] = '{payload[i], 1'b0, 1'b0, 1'b0};
        n++;
      end
      seq[n] = '{lcdtw_pkg::CMD_TRAIL_BIT, 1'b0, 1'b0, 1'b0};
      n++;
    end else begin
      if (opening) begin
        for (i = lcdtw_pkg::ADDRESS_BITS - 1; i >= 0; i--) begin
          seq[n] = '{address[i], 1'b0, 1'b0, 1'b0};
          n++;
        end
      end
      for (i = lcdtw_pkg::DATA_BITS - 1; i >= 0; i--) begin
        seq[n] = '{payload[i], 1'b0, 1'b0, 1'b0};
        n++;
      end
    end
    seq[n-1].last = 1'b1;
    if (close) begin
      seq[n-1].frame_end = 1'b1;
      link_open = 1'b0;
    end
    for (i = 0; i < n; i++) expected_bits.push_back(seq[i]);
  endtask

  task automatic add_item(input logic op, input logic [7:0] payload,
                          input logic [5:0] address, input logic close);
    lcd_item_t it;
    it = '{op, payload, address, close, (pending_items.size() == DRAIN_INDEX)};
    pending_items.push_back(it);
  endtask

  // sender: bursts of items with random gaps between them
  always @(posedge clk) begin : driver
    lcd_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      link_open = 1'b0;
      link_kind = lcdtw_pkg::OP_CMD;
    end else begin
      if (in_valid && !in_stall) begin
        serialize_item(in_operation, in_payload, in_address, in_close_frame);
        items_taken <= items_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_items[0].drain && expected_bits.size() != 0) begin
          in_valid <= 1'b0;
        end else begin
          nxt = pending_items.pop_front();
          in_valid       <= 1'b1;
          in_operation   <= nxt.op;
          in_payload     <= nxt.payload;
          in_address     <= nxt.address;
          in_close_frame <= nxt.close;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // receiver: stall pattern changes by phase, one long hold-off
  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (!holdoff_done && items_taken >= 120) begin
        holdoff_left = 400;
        holdoff_done = 1'b1;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else begin
        if (phase_left == 0) begin
          stall_mode = $urandom_range(STALL_NONE, STALL_PATTERN);
          phase_left = $urandom_range(50, 300);
        end
        phase_left--;
        pattern_cnt++;
        case (stall_mode)
          STALL_NONE: begin
            out_stall <= 1'b0;
          end
          STALL_LIGHT: begin
            out_stall <= ($urandom_range(0, 9) < 3);
          end
          STALL_HEAVY: begin
            out_stall <= ($urandom_range(0, 9) < 7);
          end
          default: begin
            out_stall <= ((pattern_cnt % 7) >= 4);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin : monitor
    lcd_bit_t got;
    lcd_bit_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_data_bit, out_frame_start, out_frame_end, out_last};
      if (expected_bits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected bit: data %b start %b end %b last %b",
                   got.data_bit, got.frame_start, got.frame_end, got.last);
      end else begin
        want = expected_bits.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("bit mismatch: expected data %b start %b end %b last %b, %s",
                     want.data_bit, want.frame_start, want.frame_end, want.last,
                     $sformatf("got data %b start %b end %b last %b",
                               got.data_bit, got.frame_start, got.frame_end, got.last));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : sequencer
    int count;
    int n;
    int k;
    logic kind;
    // one-item command frames, payload extremes
    add_item(lcdtw_pkg::OP_CMD, 8'h00, 6'h00, 1'b1);
    add_item(lcdtw_pkg::OP_CMD, 8'hFF, 6'h3F, 1'b1);
    // command frame carried over several items
    add_item(lcdtw_pkg::OP_CMD, 8'h80, 6'h00, 1'b0);
    add_item(lcdtw_pkg::OP_CMD, 8'h01, 6'h3F, 1'b0);
    add_item(lcdtw_pkg::OP_CMD, 8'h5A, 6'h00, 1'b1);
    // write frame, address only on the opener
    add_item(lcdtw_pkg::OP_WRITE, 8'h00, 6'h00, 1'b0);
    add_item(lcdtw_pkg::OP_WRITE, 8'hFF, 6'h3F, 1'b0);
    add_item(lcdtw_pkg::OP_WRITE, 8'h3C, 6'h15, 1'b1);
    // one-item write frame
    add_item(lcdtw_pkg::OP_WRITE, 8'hA5, 6'h3F, 1'b1);
    // kind changes inside an open frame
    add_item(lcdtw_pkg::OP_CMD, 8'h12, 6'h2A, 1'b0);
    add_item(lcdtw_pkg::OP_WRITE, 8'h81, 6'h2A, 1'b0);
    add_item(lcdtw_pkg::OP_CMD, 8'hC3, 6'h00, 1'b0);
    add_item(lcdtw_pkg::OP_WRITE, 8'h7E, 6'h15, 1'b1);
    add_item(lcdtw_pkg::OP_WRITE, 8'hFF, 6'h3F, 1'b0);
    add_item(lcdtw_pkg::OP_WRITE, 8'h00, 6'h00, 1'b1);
    add_item(lcdtw_pkg::OP_CMD, 8'hAA, 6'h3F, 1'b1);
    count = 0;
    while (count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        add_item(1'($urandom_range(0, 1)), 8'($urandom), 6'($urandom),
                 1'($urandom_range(0, 1)));
        count++;
      end else begin
        kind = 1'($urandom_range(0, 1));
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) add_item(kind, 8'($urandom), 6'($urandom), (k == n - 1));
        count += n;
      end
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_bits.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_bits.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
